// ===== hdl/msbbr_pkg.sv =====
package msbbr_pkg;

   localparam int POS_W  = 13;
   localparam int BIT_W  = 3;
   localparam int WIDX_W = 12;
   localparam int BYTE_W = 8;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 2;

   typedef enum logic [2:0] {
      ACT_WRITE   = 3'd0,
      ACT_BIT     = 3'd1,
      ACT_BYTE    = 3'd2,
      ACT_U8      = 3'd3,
      ACT_A16     = 3'd4,
      ACT_U16     = 3'd5,
      ACT_A32     = 3'd6,
      ACT_REWIND  = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WRITE,
      OP_BIT,
      OP_ALIGNED,
      OP_HI,
      OP_LO,
      OP_REWIND
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_REWIND,
      ST_BIT,
      ST_ALIGNED,
      ST_HI,
      ST_LO,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic   load;
      op_type op;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic need_lo;
   } stat_type;

endpackage

// ===== hdl/msbbr_ram.sv =====
module msbbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ===== hdl/msbbr_dpath.sv =====
module msbbr_dpath #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  msbbr_pkg::cmd_type           cmd,
   output msbbr_pkg::stat_type          stat,
   input  logic [msbbr_pkg::WIDX_W-1:0] req_write_index,
   input  logic [msbbr_pkg::BYTE_W-1:0] req_write_byte,
   input  logic                         csr_we,
   input  logic [msbbr_pkg::POS_W-1:0]  csr_wdata,
   output logic [msbbr_pkg::VAL_W-1:0]  rsp_value,
   output logic                         rsp_at_end
);

   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int CMP_W = 17;
   localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(STORE_DEPTH);

   logic [msbbr_pkg::POS_W-1:0]  pos_ff, pos_in, len_ff, pos_inc;
   logic [msbbr_pkg::BIT_W-1:0]  bit_ff, bit_in;
   logic [msbbr_pkg::VAL_W-1:0]  acc_ff, acc_in, val_ff;
   logic [msbbr_pkg::WIDX_W-1:0] widx_ff, widx_in;
   logic [msbbr_pkg::BYTE_W-1:0] wbyte_ff, wbyte_in;
   logic                         at_end_ff;

   logic [AW-1:0]                ram_addr;
   logic                         ram_we;
   logic [msbbr_pkg::BYTE_W-1:0] ram_rdata, cur, shl, shr, lo;
   logic                         pos_ok, in_store, widx_ok;

   msbbr_ram #(
      .WIDTH(msbbr_pkg::BYTE_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(wbyte_ff),
      .rdata(ram_rdata)
   );

   // read data belongs to pos_ff except after a write: the address follows pos_in, or widx_ff in OP_WRITE
   assign pos_ok   = pos_ff < len_ff;
   assign in_store = {{(CMP_W-msbbr_pkg::POS_W){1'b0}}, pos_ff} < DEPTH_W;
   assign widx_ok  = {{(CMP_W-msbbr_pkg::WIDX_W){1'b0}}, widx_ff} < DEPTH_W;
   assign cur      = in_store ? ram_rdata : 8'h00;
   assign pos_inc  = pos_ff + 13'd1;
   assign shl      = cur << bit_ff;
   assign shr      = cur >> (4'd8 - {1'b0, bit_ff});
   assign lo       = pos_ok ? shr : 8'h00;

   assign stat.need_lo = pos_ok && (bit_ff != 3'd0);

   always_comb begin
      pos_in   = pos_ff;
      bit_in   = bit_ff;
      acc_in   = acc_ff;
      widx_in  = widx_ff;
      wbyte_in = wbyte_ff;
      case (cmd.op)
         msbbr_pkg::OP_BIT: begin
            if (pos_ok) begin
               acc_in = {acc_ff[30:0], cur[3'd7 - bit_ff]};
               if (bit_ff == 3'd7) begin
                  bit_in = 3'd0;
                  pos_in = pos_inc;
               end else begin
                  bit_in = bit_ff + 3'd1;
               end
            end else begin
               acc_in = {acc_ff[30:0], 1'b0};
            end
         end
         msbbr_pkg::OP_ALIGNED: begin
            if (pos_ok) begin
               acc_in = {acc_ff[23:0], cur};
               pos_in = pos_inc;
               bit_in = 3'd0;
            end else begin
               acc_in = {acc_ff[23:0], 8'h00};
            end
         end
         msbbr_pkg::OP_HI: begin
            // bit offset is kept; the low part follows in OP_LO when nonzero
            if (pos_ok) begin
               acc_in = {acc_ff[23:0], shl};
               pos_in = pos_inc;
            end else begin
               acc_in = {acc_ff[23:0], 8'h00};
            end
         end
         msbbr_pkg::OP_LO: begin
            acc_in = {acc_ff[31:8], acc_ff[7:0] | lo};
         end
         msbbr_pkg::OP_REWIND: begin
            pos_in = '0;
            bit_in = '0;
         end
         default: begin
         end
      endcase
      if (cmd.load) begin
         acc_in   = '0;
         widx_in  = req_write_index;
         wbyte_in = req_write_byte;
      end
   end

   always_comb begin
      ram_we   = (cmd.op == msbbr_pkg::OP_WRITE) && widx_ok;
      ram_addr = (cmd.op == msbbr_pkg::OP_WRITE) ? AW'(widx_ff) : AW'(pos_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         bit_ff <= '0;
         len_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         bit_ff <= bit_in;
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      widx_ff  <= widx_in;
      wbyte_ff <= wbyte_in;
      if (cmd.out_load) begin
         val_ff    <= acc_ff;
         at_end_ff <= len_ff <= pos_ff;
      end
   end

   assign rsp_value  = val_ff;
   assign rsp_at_end = at_end_ff;

endmodule

// ===== hdl/msbbr_ctrl.sv =====
module msbbr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  msbbr_pkg::action_type req_action,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  msbbr_pkg::stat_type   stat,
   output msbbr_pkg::cmd_type    cmd
);

   msbbr_pkg::state_type           state_ff, state_in;
   logic [msbbr_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msbbr_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_tready   = 1'b0;
      cmd.load     = 1'b0;
      cmd.op       = msbbr_pkg::OP_NONE;
      cmd.out_load = 1'b0;
      case (state_ff)
         msbbr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = 2'd0;
               case (req_action)
                  msbbr_pkg::ACT_WRITE: state_in = msbbr_pkg::ST_WRITE;
                  msbbr_pkg::ACT_BIT:   state_in = msbbr_pkg::ST_BIT;
                  msbbr_pkg::ACT_BYTE:  state_in = msbbr_pkg::ST_ALIGNED;
                  msbbr_pkg::ACT_U8:    state_in = msbbr_pkg::ST_HI;
                  msbbr_pkg::ACT_A16: begin
                     state_in = msbbr_pkg::ST_ALIGNED;
                     cnt_in   = 2'd1;
                  end
                  msbbr_pkg::ACT_U16: begin
                     state_in = msbbr_pkg::ST_HI;
                     cnt_in   = 2'd1;
                  end
                  msbbr_pkg::ACT_A32: begin
                     state_in = msbbr_pkg::ST_ALIGNED;
                     cnt_in   = 2'd3;
                  end
                  default: state_in = msbbr_pkg::ST_REWIND;
               endcase
            end
         end
         msbbr_pkg::ST_WRITE: begin
            cmd.op   = msbbr_pkg::OP_WRITE;
            state_in = msbbr_pkg::ST_FINISH;
         end
         msbbr_pkg::ST_REWIND: begin
            cmd.op   = msbbr_pkg::OP_REWIND;
            state_in = msbbr_pkg::ST_FINISH;
         end
         msbbr_pkg::ST_BIT: begin
            cmd.op   = msbbr_pkg::OP_BIT;
            state_in = msbbr_pkg::ST_FINISH;
         end
         msbbr_pkg::ST_ALIGNED: begin
            cmd.op = msbbr_pkg::OP_ALIGNED;
            if (cnt_ff == 2'd0) begin
               state_in = msbbr_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff - 2'd1;
            end
         end
         msbbr_pkg::ST_HI: begin
            cmd.op = msbbr_pkg::OP_HI;
            if (stat.need_lo) begin
               state_in = msbbr_pkg::ST_LO;
            end else if (cnt_ff == 2'd0) begin
               state_in = msbbr_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff - 2'd1;
            end
         end
         msbbr_pkg::ST_LO: begin
            cmd.op = msbbr_pkg::OP_LO;
            if (cnt_ff == 2'd0) begin
               state_in = msbbr_pkg::ST_FINISH;
            end else begin
               cnt_in   = cnt_ff - 2'd1;
               state_in = msbbr_pkg::ST_HI;
            end
         end
         msbbr_pkg::ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = msbbr_pkg::ST_IDLE;
            end
         end
         default: state_in = msbbr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/msb_first_bitstream_reader.sv =====
// Channel  Dir  Ports                                  Contents
// req      in   req_tvalid/tready, tdata[23:0], tuser   action, write index, write byte
// rsp      out  rsp_tvalid/tready, tdata[31:0], tuser   read value, at-end flag
// csr      in   csr_we, csr_wdata[12:0]                 buffer length
//
// One request at a time: accept, a single step for write, rewind or bit, or one step
// per byte otherwise, then a load of the output register. Unaligned reads take an
// extra step per byte when the bit offset is nonzero. The single-port byte store gives
// one byte a cycle.
// Synchronous reset clears position, length and control; store contents are kept.
// A pending response stalls completion of the next request, not its acceptance.
module msb_first_bitstream_reader #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] write_index, [19:12] write_byte
   input  logic [2:0]  req_tuser,   // [2:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] read_value
   output logic [0:0]  rsp_tuser,   // [0] at_end
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);

   msbbr_pkg::cmd_type  ctrl_cmd;
   msbbr_pkg::stat_type dp_stat;

   msbbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_action(msbbr_pkg::action_type'(req_tuser)),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   msbbr_dpath #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctrl_cmd),
      .stat           (dp_stat),
      .req_write_index(req_tdata[11:0]),
      .req_write_byte (req_tdata[19:12]),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_value      (rsp_tdata),
      .rsp_at_end     (rsp_tuser[0])
   );

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still in progress");

   a_lo_follows_hi: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.op == msbbr_pkg::OP_LO |-> $past(ctrl_cmd.op) == msbbr_pkg::OP_HI)
      else $error("low-part step without preceding high-part step");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_load |=> rsp_tvalid)
      else $error("response loaded but not presented");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_load |-> !rsp_tvalid || rsp_tready)
      else $error("response overwritten before transfer");

endmodule

// ===== tb/msb_first_bitstream_reader_tb.sv =====
module msb_first_bitstream_reader_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = 4096;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 195;
   localparam int NUM_PHASES    = 10;

   typedef struct packed {
      logic [msbbr_pkg::VAL_W-1:0] value;
      logic                        at_end;
   } field_reply_type;

   // Tracks the reader's position and store, and queues the reply of each request.
   class msb_field_board;
      logic [msbbr_pkg::BYTE_W-1:0] store [DEPTH];
      bit                           written [DEPTH];
      logic [msbbr_pkg::POS_W-1:0]  byte_pos;
      logic [msbbr_pkg::POS_W-1:0]  buf_len;
      int unsigned                  bit_pos;
      bit                           hit_gap;
      field_reply_type              expected_fields [$];
      int                           mismatches;
      int                           replies_checked;

      function new();
         byte_pos = '0;
         buf_len = '0;
         bit_pos = 0;
         mismatches = 0;
         replies_checked = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void set_length(logic [msbbr_pkg::POS_W-1:0] len);
         buf_len = len;
      endfunction

      function logic [msbbr_pkg::VAL_W-1:0] fetch(logic [msbbr_pkg::POS_W-1:0] addr);
         if (addr >= DEPTH) return '0;
         if (!written[addr]) hit_gap = 1'b1;
         return msbbr_pkg::VAL_W'(store[addr]);
      endfunction

      function void advance();
         if (byte_pos < buf_len) begin
            byte_pos = byte_pos + 1'b1;
            bit_pos = 0;
         end
      endfunction

      function logic [msbbr_pkg::VAL_W-1:0] take_aligned();
         logic [msbbr_pkg::VAL_W-1:0] v;
         if (byte_pos >= buf_len) return '0;
         v = fetch(byte_pos);
         advance();
         return v;
      endfunction

      function logic [msbbr_pkg::VAL_W-1:0] take_unaligned();
         int unsigned                 b;
         logic [msbbr_pkg::VAL_W-1:0] hi;
         logic [msbbr_pkg::VAL_W-1:0] nxt;
         if (byte_pos >= buf_len) return '0;
         b = bit_pos & 7;
         if (b == 0) begin
            hi = fetch(byte_pos);
            advance();
            return hi;
         end
         hi = (take_aligned() << b) & 32'hFF;
         // next byte counts as zero once it lies past the buffer
         nxt = (byte_pos < buf_len) ? fetch(byte_pos) : '0;
         bit_pos = b;
         return (hi | (nxt >> (8 - b))) & 32'hFF;
      endfunction

      function logic [msbbr_pkg::VAL_W-1:0] take_bit();
         logic [msbbr_pkg::VAL_W-1:0] v;
         if (byte_pos >= buf_len) return '0;
         v = (fetch(byte_pos) >> (7 - bit_pos)) & 32'h1;
         bit_pos = (bit_pos + 1) & 15;
         if (bit_pos >= 8) begin
            bit_pos = 0;
            advance();
         end
         return v;
      endfunction

      function field_reply_type step_fields(msbbr_pkg::action_type act,
                                            logic [msbbr_pkg::WIDX_W-1:0] widx,
                                            logic [msbbr_pkg::BYTE_W-1:0] wbyte);
         field_reply_type             r;
         logic [msbbr_pkg::VAL_W-1:0] a, b, c, d;
         r.value = '0;
         case (act)
            msbbr_pkg::ACT_WRITE: begin
               store[widx] = wbyte;
               written[widx] = 1'b1;
            end
            msbbr_pkg::ACT_BIT:  r.value = take_bit();
            msbbr_pkg::ACT_BYTE: r.value = take_aligned();
            msbbr_pkg::ACT_U8:   r.value = take_unaligned();
            msbbr_pkg::ACT_A16: begin
               a = take_aligned();
               b = take_aligned();
               r.value = (a << 8) | b;
            end
            msbbr_pkg::ACT_U16: begin
               a = take_unaligned();
               b = take_unaligned();
               r.value = (a << 8) | b;
            end
            msbbr_pkg::ACT_A32: begin
               a = take_aligned();
               b = take_aligned();
               c = take_aligned();
               d = take_aligned();
               r.value = (a << 24) | (b << 16) | (c << 8) | d;
            end
            default: begin
               byte_pos = '0;
               bit_pos = 0;
            end
         endcase
         r.at_end = (buf_len <= byte_pos);
         return r;
      endfunction

      // dry run of a read: would it fetch a store entry never written?
      function bit reaches_unwritten(msbbr_pkg::action_type act);
         logic [msbbr_pkg::POS_W-1:0] saved_byte;
         int unsigned                 saved_bit;
         field_reply_type             unused;
         saved_byte = byte_pos;
         saved_bit = bit_pos;
         hit_gap = 1'b0;
         unused = step_fields(act, '0, '0);
         byte_pos = saved_byte;
         bit_pos = saved_bit;
         return hit_gap;
      endfunction

      function void note_request(msbbr_pkg::action_type act,
                                 logic [msbbr_pkg::WIDX_W-1:0] widx,
                                 logic [msbbr_pkg::BYTE_W-1:0] wbyte);
         expected_fields.insert(expected_fields.size(), step_fields(act, widx, wbyte));
      endfunction

      function void check_reply(logic [msbbr_pkg::VAL_W-1:0] value, logic at_end);
         field_reply_type e;
         if (expected_fields.size() == 0) begin
            $display("%0t: unexpected result, expected none, got value %h at_end %b",
                     $time, value, at_end);
            mismatches++;
            return;
         end
         e = expected_fields.pop_front();
         replies_checked++;
         if (value !== e.value) begin
            $display("%0t: read_value expected %h, got %h", $time, e.value, value);
            mismatches++;
         end
         if (at_end !== e.at_end) begin
            $display("%0t: at_end expected %b, got %b", $time, e.at_end, at_end);
            mismatches++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [23:0]                    req_tdata = '0;   // [11:0] write_index, [19:12] write_byte
   logic [2:0]                     req_tuser = '0;   // [2:0] action
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [31:0]                    rsp_tdata;        // [31:0] read_value
   logic [0:0]                     rsp_tuser;        // [0] at_end
   logic                           csr_we = 1'b0;
   logic [msbbr_pkg::POS_W-1:0]    csr_wdata = '0;

   msb_field_board board;
   int  req_idle_pct = 16;
   int  rsp_idle_pct = 55;
   bit  hold_request = 1'b0;
   bit  req_held = 1'b0;
   int  action_count [8];
   int  lengths_written = 0;
   int  random_sent = 0;

   msb_first_bitstream_reader uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when asked
   initial begin : reply_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_reply(rsp_tdata, rsp_tuser[0]);
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_request(msbbr_pkg::action_type act,
                               logic [msbbr_pkg::WIDX_W-1:0] widx,
                               logic [msbbr_pkg::BYTE_W-1:0] wbyte);
      int gap;
      gap = 0;
      if ($urandom_range(99) < req_idle_pct)
         gap = ($urandom_range(49) == 0) ? 15 : $urandom_range(1, 4);
      if (gap > 0) begin
         if (req_held) req_tvalid <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {4'b0, wbyte, widx};
      req_held = 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(act, widx, wbyte);
      action_count[act]++;
   endtask

   // drop valid, wait for every reply, then let the block go quiet
   task automatic settle();
      if (req_held) req_tvalid <= 1'b0;
      req_held = 1'b0;
      do @(posedge clock); while (board.expected_fields.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(logic [msbbr_pkg::POS_W-1:0] len);
      csr_we <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_length(len);
      lengths_written++;
      @(posedge clock);
   endtask

   task automatic send_random();
      msbbr_pkg::action_type        act;
      logic [msbbr_pkg::WIDX_W-1:0] widx;
      int                           pick;
      int                           limit;
      int                           addr;
      pick = $urandom_range(99);
      widx = '0;
      if (pick < 28) begin
         act = msbbr_pkg::ACT_WRITE;
         limit = (board.buf_len + 8 > DEPTH - 1) ? DEPTH - 1 : board.buf_len + 8;
         widx = msbbr_pkg::WIDX_W'($urandom_range(1) ? $urandom_range(DEPTH - 1)
                                                     : $urandom_range(limit));
      end else if (pick < 33 || (board.buf_len <= board.byte_pos && pick < 55)) begin
         act = msbbr_pkg::ACT_REWIND;
      end else begin
         pick = $urandom_range(9);
         // bits weighted up so offsets cover every phase of a byte
         if (pick < 4) act = msbbr_pkg::ACT_BIT;
         else act = msbbr_pkg::action_type'(int'(msbbr_pkg::ACT_BYTE) + pick - 4);
         if (board.reaches_unwritten(act)) begin
            // fill the hole the read would hit instead
            addr = int'(board.byte_pos);
            while (board.written[addr]) addr++;
            act = msbbr_pkg::ACT_WRITE;
            widx = msbbr_pkg::WIDX_W'(addr);
         end
      end
      send_request(act, widx, msbbr_pkg::BYTE_W'($urandom_range(255)));
      random_sent++;
      if (random_sent < 650) begin
         req_idle_pct = 16;
         rsp_idle_pct = 55;
      end else if (random_sent < 1300) begin
         req_idle_pct = 55;
         rsp_idle_pct = 16;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
   endtask

   initial begin : stimulus
      int                           lengths [NUM_PHASES];
      logic [msbbr_pkg::BYTE_W-1:0] pattern [8];
      board = new();
      pattern = '{8'hA5, 8'h3C, 8'hFF, 8'h00, 8'h81, 8'h7E, 8'h12, 8'hC3};
      lengths = '{4096, 1, 0, 37, 300, 2, 0, 4096, 64, 9};
      lengths[6] = $urandom_range(3, 700);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero length: reads return nothing and report the end
      send_request(msbbr_pkg::ACT_BIT, '0, '0);
      send_request(msbbr_pkg::ACT_A32, '0, '0);
      for (int i = 0; i < 8; i++)
         send_request(msbbr_pkg::ACT_WRITE, msbbr_pkg::WIDX_W'(i), pattern[i]);
      send_request(msbbr_pkg::ACT_WRITE, 12'hFFF, 8'h5A);
      settle();
      write_length(13'd6);
      send_request(msbbr_pkg::ACT_BIT, '0, '0);
      send_request(msbbr_pkg::ACT_BIT, '0, '0);
      send_request(msbbr_pkg::ACT_BIT, '0, '0);
      send_request(msbbr_pkg::ACT_U8, '0, '0);
      send_request(msbbr_pkg::ACT_U16, '0, '0);
      send_request(msbbr_pkg::ACT_A16, '0, '0);    // drops the partial byte
      send_request(msbbr_pkg::ACT_BYTE, '0, '0);
      send_request(msbbr_pkg::ACT_U8, '0, '0);     // at the end
      send_request(msbbr_pkg::ACT_A32, '0, '0);
      send_request(msbbr_pkg::ACT_REWIND, '0, '0);
      send_request(msbbr_pkg::ACT_A32, '0, '0);
      send_request(msbbr_pkg::ACT_BYTE, '0, '0);
      send_request(msbbr_pkg::ACT_BIT, '0, '0);
      send_request(msbbr_pkg::ACT_U8, '0, '0);     // next byte lies past the end
      send_request(msbbr_pkg::ACT_A16, '0, '0);
      send_request(msbbr_pkg::ACT_REWIND, '0, '0);
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_length(msbbr_pkg::POS_W'(lengths[p]));
         if (p == 3 || p == 8) hold_request = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2 && p % 2 == 1) settle();
            send_random();
         end
         settle();
      end

      $display("Sent %0d requests: %0d writes, %0d bit, %0d byte, %0d u8,",
               action_count.sum(), action_count[msbbr_pkg::ACT_WRITE],
               action_count[msbbr_pkg::ACT_BIT], action_count[msbbr_pkg::ACT_BYTE],
               action_count[msbbr_pkg::ACT_U8]);
      $display("%0d a16, %0d u16, %0d a32, %0d rewinds; %0d replies over %0d lengths",
               action_count[msbbr_pkg::ACT_A16], action_count[msbbr_pkg::ACT_U16],
               action_count[msbbr_pkg::ACT_A32], action_count[msbbr_pkg::ACT_REWIND],
               board.replies_checked, lengths_written);
      if (board.mismatches == 0 && board.expected_fields.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
